/* design/fpam_pkg.sv */
// Shared types, register codes and the slot-word encoder for the PCM slot encoder.
// No dependencies; every other design file of the block but the checker imports this package.
package fpam_pkg;

	localparam int MAX_SLOTS  = 32;
	localparam int SLOT_W     = 5;
	localparam int POS_W      = 6;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SLOTS = 2'd1;
	localparam logic [1:0] REG_CHANS = 2'd2;

	localparam logic [1:0] MODE_AM824 = 2'd0;
	localparam logic [1:0] MODE_RAW   = 2'd1;
	localparam logic [1:0] MODE_SWAP  = 2'd2;

	localparam logic [23:0] FULL_SCALE = 24'h7FFFFF;
	localparam logic [31:0] AM824_LABEL = 32'h40000000;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_FULL,
		CLS_NORM
	} cls_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [POS_W-1:0] slots;
		logic [POS_W-1:0] chans;
	} cfg_t;

	typedef struct packed {
		logic [31:0]       sample;
		logic              emit;
		logic [SLOT_W-1:0] pos;
		logic              pad_on;
		logic [POS_W-1:0]  pad_lo;
		logic [POS_W-1:0]  pad_hi;
	} entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] idx;
		logic              last;
	} meta_t;

	function automatic logic [31:0] encode_word(input logic [1:0] mode, input logic [23:0] q);
		logic [31:0] v;
		begin
			v = {{8{q[23]}}, q};
			case (mode)
				MODE_RAW:   encode_word = v;
				MODE_SWAP:  encode_word = {v[7:0], v[15:8], v[23:16], v[31:24]};
				default:    encode_word = AM824_LABEL | {8'h00, q};
			endcase
		end
	endfunction

endpackage

/* design/fpam_front.sv */
// Front end: accepts samples, tracks the channel position in the frame and classifies
// each sample into a queue entry (slot to fill, padding run). Uses fpam_pkg.
module fpam_front (
	input  logic           clk,
	input  logic           arst_n,
	input  fpam_pkg::cfg_t cfg,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic [31:0]    in_bits,
	output fpam_pkg::entry_t entry
);
	import fpam_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] slots;
	logic [POS_W-1:0] chans;
	logic             last;

	always_comb begin
		slots = (cfg.slots > POS_W'(MAX_SLOTS)) ? POS_W'(MAX_SLOTS) : cfg.slots;
		chans = (cfg.chans == '0) ? POS_W'(1) : cfg.chans;
		last  = ({1'b0, pos_q} + 7'd1) >= {1'b0, chans};
		entry.sample = in_bits;
		entry.emit   = pos_q < slots;
		entry.pos    = pos_q[SLOT_W-1:0];
		entry.pad_on = last && (chans < slots);
		entry.pad_lo = chans;
		entry.pad_hi = slots;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_valid && in_ready) begin
			pos_q <= last ? '0 : pos_q + POS_W'(1);
		end
	end

endmodule

/* design/fpam_fifo.sv */
// Short queue of classified entries between the front and back ends.
// Uses fpam_pkg for the entry type and depth.
module fpam_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fpam_pkg::entry_t wr_entry,
	input  logic             pop,
	output fpam_pkg::entry_t rd_entry,
	output logic             full,
	output logic             empty
);
	import fpam_pkg::*;

	entry_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full     = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty    = count_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/fpam_conv.sv */
// Four-stage float to signed 24-bit conversion: clamp, scale by full scale in binary32,
// bias by one half in binary32 and truncate. Uses fpam_pkg.
module fpam_conv (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     in_bits,
	input  fpam_pkg::meta_t in_meta,
	output logic            out_valid,
	output logic [23:0]     out_q,
	output fpam_pkg::meta_t out_meta
);
	import fpam_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	meta_t       meta_s1, meta_s2, meta_s3, meta_s4;
	logic        sign_s1, sign_s2, sign_s3;
	cls_t        cls_s1, cls_s2, cls_s3;
	logic [23:0] m_s1;
	logic [7:0]  e_s1, e_s2;
	logic [46:0] p_s2;
	logic [23:0] mx_s3;
	logic [5:0]  ex_s3;
	logic [23:0] r_s4;

	// Stage 1 classification.
	cls_t        cls_d;
	logic [7:0]  e_in;
	logic [22:0] f_in;

	always_comb begin
		e_in = in_bits[30:23];
		f_in = in_bits[22:0];
		if (e_in == 8'hFF && f_in != '0)   cls_d = CLS_ZERO;
		else if (e_in >= 8'd127)           cls_d = CLS_FULL;
		else if (e_in < 8'd102)            cls_d = CLS_ZERO;
		else                               cls_d = CLS_NORM;
	end

	// Stage 3 normalize and round the product to 24 significant bits.
	logic [23:0] mant;
	logic        guard, sticky, rnd;
	logic [24:0] msum;
	logic [8:0]  exb;

	always_comb begin
		if (p_s2[46]) begin
			mant   = p_s2[46:23];
			guard  = p_s2[22];
			sticky = |p_s2[21:0];
			exb    = {1'b0, e_s2} - 9'd104;
		end else begin
			mant   = p_s2[45:22];
			guard  = p_s2[21];
			sticky = |p_s2[20:0];
			exb    = {1'b0, e_s2} - 9'd105;
		end
		rnd  = guard & (sticky | mant[0]);
		msum = {1'b0, mant} + {24'd0, rnd};
	end

	// Stage 4 add one half, round, truncate toward zero and apply the sign.
	logic signed [5:0] exs;
	logic [4:0]  d;
	logic [24:0] half;
	logic [24:0] s;
	logic [24:0] sp;
	logic [24:0] shv;
	logic [23:0] r;

	always_comb begin
		exs  = $signed(ex_s3);
		d    = 5'(ex_s3 + 6'd1);
		half = 25'd1 << (5'd23 - d);
		s    = {1'b0, mx_s3} + half;
		sp   = {1'b0, s[24:1]} + {24'd0, s[0] & s[1]};
		shv  = '0;
		case (cls_s3)
			CLS_FULL: r = FULL_SCALE;
			CLS_NORM: begin
				if (exs < -6'sd1) begin
					r = (exs == -6'sd2 && mx_s3 == 24'hFFFFFF) ? 24'd1 : 24'd0;
				end else begin
					if (s[24]) shv = sp >> (5'd22 - 5'(ex_s3));
					else       shv = s >> (5'd23 - 5'(ex_s3));
					r = shv[23:0];
				end
			end
			default: r = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= in_meta;
			sign_s1 <= in_bits[31];
			cls_s1  <= cls_d;
			m_s1    <= {1'b1, f_in};
			e_s1    <= e_in;

			meta_s2 <= meta_s1;
			sign_s2 <= sign_s1;
			cls_s2  <= cls_s1;
			e_s2    <= e_s1;
			p_s2    <= 47'(m_s1 * FULL_SCALE[22:0]);

			meta_s3 <= meta_s2;
			sign_s3 <= sign_s2;
			cls_s3  <= cls_s2;
			mx_s3   <= msum[24] ? 24'h800000 : msum[23:0];
			ex_s3   <= msum[24] ? 6'(exb + 9'd1) : exb[5:0];

			meta_s4 <= meta_s3;
			r_s4    <= sign_s3 ? (~r + 24'd1) : r;
		end
	end

	assign out_valid = v_s4;
	assign out_q     = r_s4;
	assign out_meta  = meta_s4;

endmodule

/* design/fpam_back.sv */
// Back end: sequences queue entries into slot requests (the sample, then the padding
// run), drives the conversion pipeline and holds the output register. Uses fpam_pkg.
module fpam_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       mode,
	input  fpam_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_word,
	output logic [4:0]       out_idx,
	output logic             out_last
);
	import fpam_pkg::*;

	logic             adv;
	logic             sample_done_q, sample_done_d;
	logic             pad_run_q, pad_run_d;
	logic [POS_W-1:0] pad_k_q, pad_k_d;
	logic [POS_W-1:0] k_cur;
	logic             issue_v;
	logic [31:0]      issue_bits;
	meta_t            issue_meta;
	logic             cv_valid;
	logic [23:0]      cv_q;
	meta_t            cv_meta;
	logic             out_valid_q;
	logic [31:0]      word_q;
	meta_t            meta_q;

	assign adv = !out_valid_q || out_ready;

	always_comb begin
		k_cur         = pad_run_q ? pad_k_q : head.pad_lo;
		issue_v       = 1'b0;
		issue_bits    = '0;
		issue_meta    = '0;
		pop           = 1'b0;
		sample_done_d = sample_done_q;
		pad_run_d     = pad_run_q;
		pad_k_d       = pad_k_q;
		if (!empty && adv) begin
			if (head.emit && !sample_done_q) begin
				issue_v         = 1'b1;
				issue_bits      = head.sample;
				issue_meta.idx  = head.pos;
				issue_meta.last = !head.pad_on;
				if (head.pad_on) sample_done_d = 1'b1;
				else             pop = 1'b1;
			end else if (head.pad_on) begin
				issue_v         = 1'b1;
				issue_meta.idx  = k_cur[SLOT_W-1:0];
				issue_meta.last = (k_cur + POS_W'(1)) == head.pad_hi;
				if (issue_meta.last) begin
					pop = 1'b1;
				end else begin
					pad_run_d = 1'b1;
					pad_k_d   = k_cur + POS_W'(1);
				end
			end else begin
				pop = 1'b1;
			end
			if (pop) begin
				sample_done_d = 1'b0;
				pad_run_d     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_done_q <= 1'b0;
			pad_run_q     <= 1'b0;
			pad_k_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			sample_done_q <= sample_done_d;
			pad_run_q     <= pad_run_d;
			pad_k_q       <= pad_k_d;
			if (adv) out_valid_q <= cv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= encode_word(mode, cv_q);
			meta_q <= cv_meta;
		end
	end

	fpam_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (issue_v),
		.in_bits   (issue_bits),
		.in_meta   (issue_meta),
		.out_valid (cv_valid),
		.out_q     (cv_q),
		.out_meta  (cv_meta)
	);

	assign out_valid = out_valid_q;
	assign out_word  = word_q;
	assign out_idx   = meta_q.idx;
	assign out_last  = meta_q.last;

endmodule

/* design/float_pcm_to_am824_slot_encoder.sv */
// Top level of the binary32 PCM to AM824 slot encoder: configuration registers,
// front end, entry queue and back end. Uses fpam_pkg, fpam_front, fpam_fifo, fpam_back.
//
// Usage
//   Input stream (s_*): one binary32 sample per request, channels of a frame interleaved.
//   Output stream (m_*): one 32-bit slot word per request, with the slot index on tuser
//   and tlast on the final word caused by an input sample.
//   Config channel (cfg_*): index 0 selects the encoding (AM824 label, raw sign-extended,
//   raw byte-swapped), index 1 the slots per frame, index 2 the source channels. It is
//   always ready and must only be written while the block is idle.
// Throughput: one sample per cycle while the queue has room. A sample that fills a
//   slot gives one slot word; the last of a frame adds one word per padding slot, from
//   the back end sequencer that issues one slot word per cycle unless the output stalls.
//   The four-entry queue absorbs short padding runs before the input sees backpressure.
// Path: an input request is written into the queue; the back end reads it there, and its
//   slot word passes the four conversion stages and is loaded into the output register.
// Reset: clears the channel position, the queue and all valid flags; the registers
//   return to AM824 mode, zero slots and one source channel.
// Stall: when m_tready is low with a slot word valid, the output word holds, the conversion pipeline freezes,
//   the queue fills, and s_tready falls once the queue is full.
module float_pcm_to_am824_slot_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] slot_word
	output logic [4:0]  m_tuser,   // [4:0] slot_index
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import fpam_pkg::*;

	cfg_t   cfg_q;
	entry_t fr_entry;
	entry_t head;
	logic   full;
	logic   empty;
	logic   pop;

	// The register file takes a write every cycle; index three is not decoded.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_AM824;
			cfg_q.slots <= '0;
			cfg_q.chans <= POS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:  cfg_q.mode  <= cfg_data[1:0];
				REG_SLOTS: cfg_q.slots <= cfg_data;
				REG_CHANS: cfg_q.chans <= cfg_data;
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	// The input is taken whenever the queue has room, independent of the output side.
	assign s_tready = !full;

	fpam_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_bits  (s_tdata),
		.entry    (fr_entry)
	);

	fpam_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid && s_tready),
		.wr_entry (fr_entry),
		.pop      (pop),
		.rd_entry (head),
		.full     (full),
		.empty    (empty)
	);

	fpam_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (cfg_q.mode),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (m_tdata),
		.out_idx   (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

/* design/fpam_checker.sv */
// Port-level checker for the slot encoder, bound to the top level.
// Sees only the top-level ports; no package dependency.
module fpam_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [4:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled slot word keeps its value, index and end marker.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled slot word changed");

	// Reset empties the output register.
	a_reset_out: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// Right after reset the queue is empty, so input is accepted.
	a_ready_after_reset: assert property (@(posedge clk) $rose(arst_n) |=> s_tready)
		else $error("input not ready after reset");

endmodule

bind float_pcm_to_am824_slot_encoder fpam_checker u_fpam_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* sim/testbench.sv */
// Self-checking testbench for float_pcm_to_am824_slot_encoder: a directed table, then random
// phases under several register settings and idle patterns. Depends on fpam_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
	import fpam_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic [4:0]  idx;
		logic        last;
	} slot_word_t;

	typedef struct {
		logic [31:0] sample;
		bit          typed;   // expected word given in the row
		logic [31:0] word;
	} table_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_MODE;
	logic [5:0]  cfg_data = '0;

	// Local copy of the registers and the frame position.
	logic [1:0]  enc_mode = MODE_AM824;
	logic [5:0]  slots_reg = '0;
	logic [5:0]  chans_reg = 6'd1;
	int unsigned frame_pos = 0;

	slot_word_t  pending_words[$];
	int          errors = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	float_pcm_to_am824_slot_encoder uut (.*);

	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("[float_pcm_to_am824_slot_encoder] ERROR");
		$finish;
	end

	// Round a nonnegative integer to 24 significant bits, ties to even, as binary32 does.
	function automatic logic [63:0] round_to_24(input logic [63:0] x);
		int          msb;
		int          sh;
		logic [63:0] keep;
		logic [63:0] rem;
		logic [63:0] half;
		begin
			msb = -1;
			for (int i = 0; i < 64; i++)
				if (x[i]) msb = i;
			if (msb < 24)
				return x;
			sh = msb - 23;
			keep = x >> sh;
			rem = x & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			if (rem > half || (rem == half && keep[0]))
				keep = keep + 1;
			return keep << sh;
		end
	endfunction

	// Binary32 sample to the signed PCM integer. The scale and the half-step bias are done
	// exactly in integers and rounded to 24 bits after each step, so the result matches
	// single-precision arithmetic without relying on the simulator's float support.
	function automatic logic [31:0] sample_to_pcm(input logic [31:0] b);
		int          ef;
		int          scale_exp;
		logic [63:0] mant;
		logic [63:0] prod;
		logic [63:0] mag;
		begin
			ef = b[30:23];
			if (ef == 255 && b[22:0] != 0)
				return '0;                          // NaN encodes as silence
			if (ef >= 127) begin
				scale_exp = 0;                      // clamp to full scale
				mant = 64'd1 << 23;
			end else if (ef < 87) begin
				return '0;                          // far below one LSB
			end else begin
				scale_exp = ef - 127;
				mant = {41'd1, b[22:0]};
			end
			// Value is mant * 2^(scale_exp - 23); the shift below stays within 23..63.
			prod = round_to_24(mant * 64'd8388607);
			prod = round_to_24(prod + (64'd1 << (22 - scale_exp)));
			mag = prod >> (23 - scale_exp);
			return b[31] ? -mag[31:0] : mag[31:0];
		end
	endfunction

	function automatic logic [31:0] encode_slot(input logic [31:0] pcm);
		case (enc_mode)
			MODE_RAW:  return pcm;
			MODE_SWAP: return {pcm[7:0], pcm[15:8], pcm[23:16], pcm[31:24]};
			default:   return AM824_LABEL | {8'h00, pcm[23:0]};
		endcase
	endfunction

	// Works out the slot words that one accepted sample causes and advances the position.
	task automatic predict_slots(input logic [31:0] sample, input bit typed,
			input logic [31:0] typed_word);
		int unsigned eff_slots;
		int unsigned eff_chans;
		bit          frame_end;
		slot_word_t  run[$];
		slot_word_t  w;
		begin
			eff_slots = (slots_reg > MAX_SLOTS) ? MAX_SLOTS : slots_reg;
			eff_chans = (chans_reg == 0) ? 1 : chans_reg;
			frame_end = (frame_pos + 1 >= eff_chans);
			if (frame_pos < eff_slots) begin
				w.word = typed ? typed_word : encode_slot(sample_to_pcm(sample));
				w.idx = frame_pos[4:0];
				w.last = 1'b0;
				run.push_back(w);
			end
			if (frame_end) begin
				for (int unsigned k = eff_chans; k < eff_slots; k++) begin
					w.word = encode_slot(32'd0);
					w.idx = k[4:0];
					w.last = 1'b0;
					run.push_back(w);
				end
				frame_pos = 0;
			end else begin
				frame_pos = (frame_pos + 1) & 6'h3F;
			end
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				pending_words.push_back(run[i]);
		end
	endtask

	// Sends one sample, idling first at the phase's rate, and waits for the request.
	task automatic send_sample(input logic [31:0] sample, input bit typed = 0,
			input logic [31:0] typed_word = '0);
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= sample;
			do @(posedge clk); while (!s_tready);
			predict_slots(sample, typed, typed_word);
		end
	endtask

	// Lowers valid, waits for every outstanding slot word, then lets the pipeline empty.
	task automatic drain;
		begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (pending_words.size() > 0)
				@(posedge clk);
			repeat (12) @(posedge clk);
		end
	endtask

	// Writes all three registers back to back; called only while the block is idle.
	task automatic set_registers(input logic [1:0] mode, input logic [5:0] slots,
			input logic [5:0] chans);
		logic [5:0] vals[3];
		begin
			vals[0] = {4'd0, mode};
			vals[1] = slots;
			vals[2] = chans;
			for (int i = 0; i < 3; i++) begin
				cfg_valid <= 1'b1;
				cfg_index <= i[1:0];
				cfg_data <= vals[i];
				do @(posedge clk); while (!cfg_ready);
			end
			cfg_valid <= 1'b0;
			enc_mode = mode;
			slots_reg = slots;
			chans_reg = chans;
		end
	endtask

	function automatic logic [31:0] random_sample;
		int pick;
		begin
			pick = $urandom_range(99);
			if (pick < 55)        // ordinary audio level in [-1, 1)
				return {1'($urandom), 8'($urandom_range(126, 100)), 23'($urandom)};
			else if (pick < 75)
				return $urandom;
			else if (pick < 85)   // small magnitudes near one LSB
				return {1'($urandom), 8'($urandom_range(110, 80)), 23'($urandom)};
			else if (pick < 92)
				return {1'($urandom), 31'h3F800000};
			else
				return {1'($urandom), 8'hFF, 23'($urandom_range(1) ? $urandom : 0)};
		end
	endfunction

	// Output side: check each slot word against the oldest expectation, then pick tready.
	always @(posedge clk) begin
		slot_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected slot word %h idx %0d last %b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				exp_w = pending_words.pop_front();
				if (m_tdata !== exp_w.word || m_tuser !== exp_w.idx || m_tlast !== exp_w.last) begin
					$display("%0t: expected word %h idx %0d last %b, got %h idx %0d last %b",
						$time, exp_w.word, exp_w.idx, exp_w.last, m_tdata, m_tuser, m_tlast);
					errors++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		table_row_t dir_table[$];
		int         n_items;

		arst_n <= 1'b0;

		// Full-scale results are +/-8388607: 0x7FFFFF and 0x800001 in 24 bits.
		dir_table = '{
			'{32'h00000000, 1, 32'h40000000},   // zero
			'{32'h80000000, 1, 32'h40000000},   // negative zero
			'{32'h3F800000, 1, 32'h407FFFFF},   // +1.0
			'{32'hBF800000, 1, 32'h40800001},   // -1.0
			'{32'h40000000, 1, 32'h407FFFFF},   // +2.0 clamps
			'{32'hC0000000, 1, 32'h40800001},   // -2.0 clamps
			'{32'h7F800000, 1, 32'h407FFFFF},   // +inf clamps
			'{32'hFF800000, 1, 32'h40800001},   // -inf clamps
			'{32'h7FC00000, 1, 32'h40000000},   // quiet NaN
			'{32'hFFFFFFFF, 1, 32'h40000000},   // NaN with every bit set
			'{32'h00000001, 1, 32'h40000000},   // smallest subnormal
			'{32'h3F000000, 0, 32'h0},
			'{32'hBF000000, 0, 32'h0},
			'{32'h3F7FFFFF, 0, 32'h0},
			'{32'hBF7FFFFF, 0, 32'h0},
			'{32'h34000000, 0, 32'h0},
			'{32'hB4000000, 0, 32'h0},
			'{32'h33FFFFFF, 0, 32'h0},
			'{32'h3E800001, 0, 32'h0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state has zero slots, so these samples are all dropped.
		for (int i = 0; i < 3; i++)
			send_sample(random_sample());
		drain();

		set_registers(MODE_AM824, 6'd1, 6'd1);
		foreach (dir_table[i])
			send_sample(dir_table[i].sample, dir_table[i].typed, dir_table[i].word);
		drain();

		// Raw, swapped and the unused mode, with padding and with oversized slot counts.
		set_registers(MODE_RAW, 6'd4, 6'd2);
		for (int i = 0; i < 4; i++) send_sample(dir_table[i].sample);
		drain();
		set_registers(MODE_SWAP, 6'd63, 6'd0);
		send_sample(32'hBF800000);
		drain();
		set_registers(2'd3, 6'd2, 6'd5);
		for (int i = 0; i < 4; i++) send_sample(dir_table[i + 2].sample);
		drain();
		// Fewer channels than the position reached: the next sample closes the frame.
		set_registers(MODE_RAW, 6'd3, 6'd2);
		send_sample(32'h3F000000);
		send_sample(32'hBF000000);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			case (ph)
				0: set_registers(MODE_AM824, 6'd32, 6'd32);
				1: set_registers(MODE_RAW, 6'd32, 6'd1);
				2: set_registers(MODE_SWAP, 6'd0, 6'd63);
				3: set_registers(2'd3, 6'd63, 6'd32);
				default: set_registers(2'($urandom_range(3)),
					6'($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(8)),
					6'($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(6)));
			endcase
			n_items = 33;
			for (int i = 0; i < n_items; i++) begin
				send_sample(random_sample());
				if (ph == 5 && i == n_items / 2)
					drain();   // hold the input until the output has caught up
			end
			drain();
		end

		recv_stall_pct = 0;
		if (errors == 0 && pending_words.size() == 0)
			$display("[float_pcm_to_am824_slot_encoder] OK");
		else
			$display("[float_pcm_to_am824_slot_encoder] ERROR");
		$finish;
	end

endmodule
